### rtl/core/pet_pkg.sv
// ----------------------------------------------------------------------------
// Priority event table package
// Shared types, codes and widths for the event table and its cells.
// ----------------------------------------------------------------------------
package pet_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ID_W = 16;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NONE      = 2'd3
  } st_t;

  typedef struct packed {
    op_t                opcode;
    logic signed [7:0]  priority_req;
    logic signed [31:0] runtime;
    logic [31:0]        task_handle;
    logic [31:0]        context_req;
    logic [15:0]        event_id;
  } in_req_t;

  typedef struct packed {
    st_t                status;
    logic [15:0]        out_id;
    logic signed [7:0]  out_priority;
    logic signed [31:0] out_runtime;
    logic [31:0]        out_handle;
    logic [31:0]        out_context;
  } out_rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic signed [7:0]  prio;
    logic signed [31:0] runtime;
    logic [31:0]        handle;
    logic [31:0]        ctx;
  } entry_t;

  typedef struct packed {
    logic   found;
    entry_t best;
  } scan_t;

  typedef struct packed {
    logic add_en;
    logic shift_en;
    logic mode_disp;
  } cell_ctl_t;

endpackage

### rtl/core/priority_event_table_top.sv
// ----------------------------------------------------------------------------
// Priority event table
// Pending events kept in insertion order in a row of cells, with add,
// remove by id and dispatch of the highest non-negative priority.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall with in_data, results leave on
// out_valid/out_stall with out_data; each request gives exactly one result.
// A request is taken only while the controller is idle, one at a time.
// Add and the unused opcode register their result from the execute state;
// remove and dispatch go through the scan state and register theirs from the
// take state, once the search wave that walks the cell row one cell per
// cycle has reached its end. The table is compacted in the same cycle the
// result is registered. The controller returns to idle as the result is
// registered, so the next request can be accepted even while that result
// still waits in the output register.
// When the receiver stalls, the result holds and a finished request waits
// for the register.
// Reset empties the table and restarts the id counter; the first id is 1.
// ----------------------------------------------------------------------------
module priority_event_table_top #(
  parameter int DEPTH = pet_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pet_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pet_pkg::out_rsp_t out_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH+1);
  localparam int CNT_W = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_TAKE = 4'b1000
  } state_t;

  state_t                       state_r, state_nxt;
  pet_pkg::in_req_t             req_r, req_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [OCC_W-1:0]             occ_r, occ_nxt;
  logic [pet_pkg::ID_W-1:0]     idctr_r, idctr_nxt;
  logic                         out_valid_r, out_valid_nxt;
  pet_pkg::out_rsp_t            out_r, out_nxt;
  logic                         out_free;
  logic                         load;
  logic [pet_pkg::ID_W-1:0]     new_id;
  pet_pkg::cell_ctl_t           ctl;
  pet_pkg::entry_t              wr_entry;

  pet_pkg::entry_t              entry_w [DEPTH+1];
  pet_pkg::scan_t               scan_w  [DEPTH+1];
  logic [IDX_W-1:0]             sidx_w  [DEPTH+1];

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign new_id   = (idctr_r == '1) ? pet_pkg::ID_W'(1) : idctr_r + pet_pkg::ID_W'(1);

  assign wr_entry.id      = new_id;
  assign wr_entry.prio    = req_r.priority_req;
  assign wr_entry.runtime = req_r.runtime;
  assign wr_entry.handle  = req_r.task_handle;
  assign wr_entry.ctx     = req_r.context_req;

  assign scan_w[0].found  = 1'b0;
  assign scan_w[0].best   = '0;
  assign sidx_w[0]        = '0;
  assign entry_w[DEPTH]   = entry_w[DEPTH-1];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    pet_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .occ          (occ_r),
      .want_id      (req_r.event_id),
      .take_idx     (sidx_w[DEPTH]),
      .wr_entry     (wr_entry),
      .right_entry  (entry_w[g+1]),
      .scan_in      (scan_w[g]),
      .scan_idx_in  (sidx_w[g]),
      .entry_o      (entry_w[g]),
      .scan_out     (scan_w[g+1]),
      .scan_idx_out (sidx_w[g+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    occ_nxt       = occ_r;
    idctr_nxt     = idctr_r;
    out_nxt       = out_r;
    load          = 1'b0;
    ctl.add_en    = 1'b0;
    ctl.shift_en  = 1'b0;
    ctl.mode_disp = (req_r.opcode == pet_pkg::OP_DISPATCH);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (req_r.opcode)
          pet_pkg::OP_REMOVE, pet_pkg::OP_DISPATCH: begin
            cnt_nxt   = '0;
            state_nxt = S_SCAN;
          end
          pet_pkg::OP_ADD: begin
            if (out_free) begin
              load      = 1'b1;
              out_nxt   = '0;
              state_nxt = S_IDLE;
              if (occ_r == OCC_W'(DEPTH)) begin
                out_nxt.status = pet_pkg::ST_FULL;
              end else begin
                ctl.add_en     = 1'b1;
                occ_nxt        = occ_r + OCC_W'(1);
                idctr_nxt      = new_id;
                out_nxt.status = pet_pkg::ST_OK;
                out_nxt.out_id = 16'(new_id);
              end
            end
          end
          default: begin
            if (out_free) begin
              load           = 1'b1;
              out_nxt        = '0;
              out_nxt.status = pet_pkg::ST_OK;
              state_nxt      = S_IDLE;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (cnt_r == CNT_W'(DEPTH-2)) begin
          state_nxt = S_TAKE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_TAKE: begin
        if (out_free) begin
          load      = 1'b1;
          out_nxt   = '0;
          state_nxt = S_IDLE;
          if (scan_w[DEPTH].found) begin
            ctl.shift_en         = 1'b1;
            occ_nxt              = occ_r - OCC_W'(1);
            out_nxt.status       = pet_pkg::ST_OK;
            out_nxt.out_id       = 16'(scan_w[DEPTH].best.id);
            out_nxt.out_priority = scan_w[DEPTH].best.prio;
            out_nxt.out_runtime  = scan_w[DEPTH].best.runtime;
            out_nxt.out_handle   = scan_w[DEPTH].best.handle;
            out_nxt.out_context  = scan_w[DEPTH].best.ctx;
          end else if (ctl.mode_disp) begin
            out_nxt.status = pet_pkg::ST_NONE;
          end else begin
            out_nxt.status = pet_pkg::ST_NOT_FOUND;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      idctr_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      idctr_r     <= idctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("table occupancy above its depth");

  a_take_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAKE && out_free && scan_w[DEPTH].found) |=>
      (occ_r == $past(occ_r) - OCC_W'(1)))
    else $error("taken entry did not shrink the table");

  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.add_en |=> (idctr_r != '0))
    else $error("id zero was assigned");

  a_disp_prio: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAKE && ctl.mode_disp && scan_w[DEPTH].found) |->
      !scan_w[DEPTH].best.prio[7])
    else $error("dispatch picked a negative priority");
`endif

endmodule

### rtl/core/pet_cell.sv
// ----------------------------------------------------------------------------
// Event table cell
// Holds one table entry, writes a new one on add, joins the search wave that
// moves one cell per cycle, and loads from its right neighbor to close a gap.
// ----------------------------------------------------------------------------
module pet_cell #(
  parameter int DEPTH = pet_pkg::DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pet_pkg::cell_ctl_t           ctl,
  input  logic [$clog2(DEPTH+1)-1:0]   occ,
  input  logic [15:0]                  want_id,
  input  logic [$clog2(DEPTH)-1:0]     take_idx,
  input  pet_pkg::entry_t              wr_entry,
  input  pet_pkg::entry_t              right_entry,
  input  pet_pkg::scan_t               scan_in,
  input  logic [$clog2(DEPTH)-1:0]     scan_idx_in,
  output pet_pkg::entry_t              entry_o,
  output pet_pkg::scan_t               scan_out,
  output logic [$clog2(DEPTH)-1:0]     scan_idx_out
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH+1);

  pet_pkg::entry_t    entry_r, entry_nxt;
  pet_pkg::scan_t     scan_r, scan_nxt;
  logic [IDX_W-1:0]   sidx_r, sidx_nxt;
  logic               cell_valid;
  logic               hit;

  assign cell_valid = OCC_W'(IDX) < occ;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.add_en && (occ == OCC_W'(IDX))) begin
      entry_nxt = wr_entry;
    end else if (ctl.shift_en && (take_idx <= IDX_W'(IDX)) && (OCC_W'(IDX+1) < occ)) begin
      entry_nxt = right_entry;
    end
  end

  always_comb begin
    if (ctl.mode_disp) begin
      hit = cell_valid && !entry_r.prio[7] &&
            (!scan_in.found || (entry_r.prio > scan_in.best.prio));
    end else begin
      hit = cell_valid && !scan_in.found && (16'(entry_r.id) == want_id);
    end
    scan_nxt.found = scan_in.found || hit;
    scan_nxt.best  = hit ? entry_r : scan_in.best;
    sidx_nxt       = hit ? IDX_W'(IDX) : scan_idx_in;
  end

  always_ff @(posedge clk) begin
    entry_r     <= entry_nxt;
    scan_r.best <= scan_nxt.best;
    sidx_r      <= sidx_nxt;
    if (!rst_n) begin
      scan_r.found <= 1'b0;
    end else begin
      scan_r.found <= scan_nxt.found;
    end
  end

  assign entry_o      = entry_r;
  assign scan_out     = scan_r;
  assign scan_idx_out = sidx_r;

endmodule
